FILE: rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, constants and control types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned IN_W          = 31;
  localparam int unsigned OUT_W         = 52;
  localparam int unsigned CNT_W         = 2;
  localparam int unsigned PROD_W        = 2 * IN_W;
  localparam int unsigned D_W           = 64;
  localparam int unsigned ROOT_W        = D_W / 2;
  localparam int unsigned REM_W         = ROOT_W + 2;
  localparam int unsigned NUM_W         = ROOT_W + 2;
  localparam int unsigned DEN_W         = IN_W + 1;
  localparam int unsigned FRAC_BITS_DEF = 20;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic valid;
    logic a_zero;
    logic d_neg;
    logic d_zero;
  } ctrl_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [D_W-1:0]    dsh;
    logic              a_neg;
    logic [IN_W-1:0]   a_mag;
    logic [IN_W-1:0]   b;
  } sq_t;

endpackage

FILE: rtl/core/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_if
// Valid/ready channels carrying coefficient words and root words.
// ----------------------------------------------------------------------------
interface qrs_coef_if;
  logic                                valid;
  logic                                ready;
  logic signed [qrs_pkg::IN_W-1:0]     coef_a;
  logic signed [qrs_pkg::IN_W-1:0]     coef_b;
  logic signed [qrs_pkg::IN_W-1:0]     coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
  logic                                valid;
  logic                                ready;
  logic        [qrs_pkg::CNT_W-1:0]    root_count;
  logic signed [qrs_pkg::OUT_W-1:0]    root_plus;
  logic signed [qrs_pkg::OUT_W-1:0]    root_minus;
  logic                                degenerate;

  modport source (output valid, root_count, root_plus, root_minus, degenerate, input ready);
  modport sink   (input valid, root_count, root_plus, root_minus, degenerate, output ready);
endinterface

FILE: rtl/core/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of the floored square root: retires two bits of the operand.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  qrs_pkg::ctrl_t ctl_i,
  input  qrs_pkg::sq_t   sq_i,
  output qrs_pkg::ctrl_t ctl_o,
  output qrs_pkg::sq_t   sq_o
);
  import qrs_pkg::*;

  ctrl_t            ctl_q;
  sq_t              sq_q, sq_d;
  logic [REM_W+1:0] rem2, trial;
  logic             ge;

  always_comb begin
    rem2  = {sq_i.rem, sq_i.dsh[D_W-1 -: 2]};
    trial = {2'b00, sq_i.root, 2'b01};
    ge    = rem2 >= trial;
    sq_d       = sq_i;
    sq_d.dsh   = {sq_i.dsh[D_W-3:0], 2'b00};
    sq_d.rem   = ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
    sq_d.root  = {sq_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq_q <= sq_d;
    end
  end

  assign ctl_o = ctl_q;
  assign sq_o  = sq_q;
endmodule

FILE: rtl/core/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of both restoring dividers (plus and minus roots).
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int unsigned QW = 54
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  qrs_pkg::ctrl_t              ctl_i,
  input  logic [qrs_pkg::DEN_W-1:0]   den_i,
  input  logic [1:0]                  neg_i,
  input  logic [1:0][qrs_pkg::DEN_W-1:0] rem_i,
  input  logic [1:0][QW-1:0]          dq_i,
  output qrs_pkg::ctrl_t              ctl_o,
  output logic [qrs_pkg::DEN_W-1:0]   den_o,
  output logic [1:0]                  neg_o,
  output logic [1:0][qrs_pkg::DEN_W-1:0] rem_o,
  output logic [1:0][QW-1:0]          dq_o
);
  import qrs_pkg::*;

  ctrl_t                   ctl_q;
  logic [DEN_W-1:0]        den_q;
  logic [1:0]              neg_q;
  logic [1:0][DEN_W-1:0]   rem_q, rem_d;
  logic [1:0][QW-1:0]      dq_q, dq_d;
  logic [1:0][DEN_W-1:0]   rem2;
  logic [1:0]              ge;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem2[l]  = {rem_i[l][DEN_W-2:0], dq_i[l][QW-1]};
      ge[l]    = rem2[l] >= den_i;
      rem_d[l] = ge[l] ? rem2[l] - den_i : rem2[l];
      dq_d[l]  = {dq_i[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_q <= den_i;
      neg_q <= neg_i;
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign ctl_o = ctl_q;
  assign den_o = den_q;
  assign neg_o = neg_q;
  assign rem_o = rem_q;
  assign dq_o  = dq_q;
endmodule

FILE: rtl/core/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in Q.FRAC_BITS fixed point.
// ----------------------------------------------------------------------------
// Takes one coefficient word per cycle and returns one root word per cycle.
// Two stages form the discriminant, a row of 32 square-root cells retires one
// root bit each, one stage forms the numerators, a row of 34 + FRAC_BITS
// divider cells retires one quotient bit each for both roots, and an output
// register holds the root word. The whole chain advances together and only
// holds while the output word waits to be taken.
module quadratic_root_solver #(
  parameter int unsigned FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrs_coef_if.sink   in_i,
  qrs_root_if.source out_o
);
  import qrs_pkg::*;

  localparam int unsigned QW = NUM_W + FRAC_BITS;

  logic adv;

  // stage 1: products
  ctrl_t                     c1_q;
  logic signed [PROD_W-1:0]  bb_q, ac_q;
  logic                      a_neg1_q;
  logic [IN_W-1:0]           a_mag1_q, b1_q;

  // stage 2: discriminant
  ctrl_t                     c2_q;
  sq_t                       sq2_q;
  logic signed [D_W-1:0]     d_s;

  ctrl_t [ROOT_W:0]          sctl;
  sq_t   [ROOT_W:0]          ssq;

  // numerator stage
  ctrl_t                     c3_q;
  logic [DEN_W-1:0]          den3_q;
  logic [1:0]                neg3_q;
  logic [1:0][QW-1:0]        dq3_q;
  logic signed [NUM_W:0]     nb, np, nm;
  logic [NUM_W-1:0]          mp, mm;

  ctrl_t [QW:0]              dctl;
  logic  [QW:0][DEN_W-1:0]   dden;
  logic  [QW:0][1:0]         dneg;
  logic  [QW:0][1:0][DEN_W-1:0] drem;
  logic  [QW:0][1:0][QW-1:0] ddq;

  logic                      out_valid_q;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [OUT_W-1:0]          rp_q, rp_d, rm_q, rm_d;
  logic                      deg_q, deg_d;

  function automatic logic [OUT_W-1:0] sat_root(input logic [QW-1:0] q, input logic neg);
    logic [D_W-1:0] qx;
    logic [D_W-1:0] r;
    qx = D_W'(q);
    if (neg && qx != '0) begin
      if (qx > (D_W'(1) << (OUT_W - 1))) begin
        qx = D_W'(1) << (OUT_W - 1);
      end
      r = D_W'(0) - qx;
    end else begin
      if (qx > ((D_W'(1) << (OUT_W - 1)) - D_W'(1))) begin
        qx = (D_W'(1) << (OUT_W - 1)) - D_W'(1);
      end
      r = qx;
    end
    return r[OUT_W-1:0];
  endfunction

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      c1_q.valid  <= in_i.valid;
      c1_q.a_zero <= in_i.coef_a == '0;
      c1_q.d_neg  <= 1'b0;
      c1_q.d_zero <= 1'b0;
      c2_q.valid  <= c1_q.valid;
      c2_q.a_zero <= c1_q.a_zero;
      c2_q.d_neg  <= d_s[D_W-1];
      c2_q.d_zero <= d_s == '0;
      c3_q        <= sctl[ROOT_W];
      out_valid_q <= dctl[QW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bb_q     <= in_i.coef_b * in_i.coef_b;
      ac_q     <= in_i.coef_a * in_i.coef_c;
      a_neg1_q <= in_i.coef_a[IN_W-1];
      a_mag1_q <= in_i.coef_a[IN_W-1] ? IN_W'(-in_i.coef_a) : IN_W'(in_i.coef_a);
      b1_q     <= in_i.coef_b;
    end
  end

  assign d_s = D_W'(bb_q) - (D_W'(ac_q) <<< 2);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq2_q.rem   <= '0;
      sq2_q.root  <= '0;
      sq2_q.dsh   <= d_s[D_W-1] ? '0 : d_s;
      sq2_q.a_neg <= a_neg1_q;
      sq2_q.a_mag <= a_mag1_q;
      sq2_q.b     <= b1_q;
    end
  end

  assign sctl[0] = c2_q;
  assign ssq[0]  = sq2_q;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (sctl[i]),
      .sq_i   (ssq[i]),
      .ctl_o  (sctl[i+1]),
      .sq_o   (ssq[i+1])
    );
  end

  always_comb begin
    nb = -((NUM_W+1)'(signed'(ssq[ROOT_W].b)));
    np = nb + (NUM_W+1)'(ssq[ROOT_W].root);
    nm = nb - (NUM_W+1)'(ssq[ROOT_W].root);
    mp = np[NUM_W] ? NUM_W'(-np) : NUM_W'(np);
    mm = nm[NUM_W] ? NUM_W'(-nm) : NUM_W'(nm);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den3_q    <= {ssq[ROOT_W].a_mag, 1'b0};
      neg3_q[0] <= np[NUM_W] ^ ssq[ROOT_W].a_neg;
      neg3_q[1] <= nm[NUM_W] ^ ssq[ROOT_W].a_neg;
      dq3_q[0]  <= {mp, FRAC_BITS'(0)};
      dq3_q[1]  <= {mm, FRAC_BITS'(0)};
    end
  end

  assign dctl[0] = c3_q;
  assign dden[0] = den3_q;
  assign dneg[0] = neg3_q;
  assign drem[0] = '0;
  assign ddq[0]  = dq3_q;

  for (genvar i = 0; i < QW; i++) begin : g_div
    qrs_div_cell #(.QW(QW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (dctl[i]),
      .den_i  (dden[i]),
      .neg_i  (dneg[i]),
      .rem_i  (drem[i]),
      .dq_i   (ddq[i]),
      .ctl_o  (dctl[i+1]),
      .den_o  (dden[i+1]),
      .neg_o  (dneg[i+1]),
      .rem_o  (drem[i+1]),
      .dq_o   (ddq[i+1])
    );
  end

  always_comb begin
    cnt_d = CNT_TWO;
    rp_d  = sat_root(ddq[QW][0], dneg[QW][0]);
    rm_d  = sat_root(ddq[QW][1], dneg[QW][1]);
    deg_d = 1'b0;
    if (dctl[QW].a_zero) begin
      cnt_d = CNT_NONE;
      rp_d  = '0;
      rm_d  = '0;
      deg_d = 1'b1;
    end else if (dctl[QW].d_neg) begin
      cnt_d = CNT_NONE;
      rp_d  = '0;
      rm_d  = '0;
    end else if (dctl[QW].d_zero) begin
      cnt_d = CNT_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt_q <= cnt_d;
      rp_q  <= rp_d;
      rm_q  <= rm_d;
      deg_q <= deg_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.root_count = cnt_q;
  assign out_o.root_plus  = rp_q;
  assign out_o.root_minus = rm_q;
  assign out_o.degenerate = deg_q;
endmodule
